FILE: hdl/ytc_pkg.sv
// Shared constants of the temporal clamp pipeline.
package ytc_pkg;

  // Port widths of a sample and of a packed prev/next pair.
  localparam int unsigned IN_W   = 16;
  localparam int unsigned PAIR_W = 2 * IN_W;

  // Default and largest sample width.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SAMPLE_BITS_MAX = IN_W;

endpackage

FILE: hdl/yadif_temporal_clamp_pixel.sv
// Top level of the deinterlacer temporal clamp for one missing-line pixel.
//
// Usage:
//   Drive the eleven in_ sample fields and raise start for one cycle per
//   request. busy stays low, so a request is taken at every edge where
//   start is high: one pixel per clock, back to back without gaps.
//   Each request yields exactly one result on out_sample, marked by a
//   one-cycle out_valid strobe, once the request has passed every register stage.
//   The pipeline is four register stages: averages and absolute
//   differences, temporal bound and spatial terms, bound widening, clamp.
//   The receiver cannot stall: results leave on their strobe cycle.
//   cfg_we with cfg_wdata writes skip_spatial_check; write it only while
//   no request is in flight.
//   Synchronous active-low reset clears the valid bits of every stage and
//   the configuration register (spatial check enabled); requests in flight
//   at reset are dropped.
module yadif_temporal_clamp_pixel
  import ytc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [IN_W-1:0]   in_prev2_above,
  input  logic [IN_W-1:0]   in_prev2_below,
  input  logic [PAIR_W-1:0] in_pair_two_above,
  input  logic [IN_W-1:0]   in_prev_at_line,
  input  logic [IN_W-1:0]   in_next_at_line,
  input  logic [PAIR_W-1:0] in_pair_two_below,
  input  logic [IN_W-1:0]   in_cur_above,
  input  logic [IN_W-1:0]   in_cur_below,
  input  logic [IN_W-1:0]   in_next2_above,
  input  logic [IN_W-1:0]   in_next2_below,
  input  logic [IN_W-1:0]   in_spatial_pred,
  output logic              out_valid,
  output logic [IN_W-1:0]   out_sample,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int unsigned SB = SAMPLE_BITS;

  logic          skip_r;
  logic          accept;
  logic          s1_valid, s3_valid;
  logic [SB-1:0] s1_avg, s1_avg_a, s1_avg_b, s1_up, s1_dn, s1_pred;
  logic [SB-1:0] s1_t0, s1_d1, s1_d2, s1_d3, s1_d4;
  logic [SB-1:0] s3_avg, s3_bound, s3_pred;

  // Every stage advances each cycle, so requests are never held off.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Hold the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
    end else if (cfg_we) begin
      skip_r <= cfg_wdata;
    end
  end

  ytc_diff #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_diff (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (accept),
    .prev2_above   (in_prev2_above),
    .prev2_below   (in_prev2_below),
    .pair_two_above(in_pair_two_above),
    .prev_at_line  (in_prev_at_line),
    .next_at_line  (in_next_at_line),
    .pair_two_below(in_pair_two_below),
    .cur_above     (in_cur_above),
    .cur_below     (in_cur_below),
    .next2_above   (in_next2_above),
    .next2_below   (in_next2_below),
    .spatial_pred  (in_spatial_pred),
    .s1_valid      (s1_valid),
    .s1_avg        (s1_avg),
    .s1_avg_a      (s1_avg_a),
    .s1_avg_b      (s1_avg_b),
    .s1_up         (s1_up),
    .s1_dn         (s1_dn),
    .s1_pred       (s1_pred),
    .s1_t0         (s1_t0),
    .s1_d1         (s1_d1),
    .s1_d2         (s1_d2),
    .s1_d3         (s1_d3),
    .s1_d4         (s1_d4)
  );

  ytc_bound #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_bound (
    .clk               (clk),
    .rst_n             (rst_n),
    .skip_spatial_check(skip_r),
    .s1_valid          (s1_valid),
    .s1_avg            (s1_avg),
    .s1_avg_a          (s1_avg_a),
    .s1_avg_b          (s1_avg_b),
    .s1_up             (s1_up),
    .s1_dn             (s1_dn),
    .s1_pred           (s1_pred),
    .s1_t0             (s1_t0),
    .s1_d1             (s1_d1),
    .s1_d2             (s1_d2),
    .s1_d3             (s1_d3),
    .s1_d4             (s1_d4),
    .s3_valid          (s3_valid),
    .s3_avg            (s3_avg),
    .s3_bound          (s3_bound),
    .s3_pred           (s3_pred)
  );

  ytc_clamp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_avg    (s3_avg),
    .s3_bound  (s3_bound),
    .s3_pred   (s3_pred),
    .out_valid (out_valid),
    .out_sample(out_sample)
  );

  // A request whose prev, next and prediction agree must come out unchanged.
  logic flat_in;
  assign flat_in = (in_prev_at_line[SB-1:0] == in_next_at_line[SB-1:0]) &&
                   (in_spatial_pred[SB-1:0] == in_prev_at_line[SB-1:0]);

  // One strobe for every accepted request.
  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4))
    |-> (out_valid == $past(accept, 4)))
    else $error("result strobe does not match request four cycles earlier");

  // The result never exceeds the sample range.
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_sample >> SB) == '0))
    else $error("result above sample range");

  // A flat neighborhood passes the prediction straight through.
  a_flat_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(accept, 4) && $past(flat_in, 4))
    |-> (out_sample[SB-1:0] == $past(in_spatial_pred[SB-1:0], 4)))
    else $error("flat neighborhood altered the prediction");

endmodule

FILE: hdl/ytc_diff.sv
// Stage one: mask the samples, form temporal averages and absolute differences.
module ytc_diff
  import ytc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [IN_W-1:0]        prev2_above,
  input  logic [IN_W-1:0]        prev2_below,
  input  logic [PAIR_W-1:0]      pair_two_above,
  input  logic [IN_W-1:0]        prev_at_line,
  input  logic [IN_W-1:0]        next_at_line,
  input  logic [PAIR_W-1:0]      pair_two_below,
  input  logic [IN_W-1:0]        cur_above,
  input  logic [IN_W-1:0]        cur_below,
  input  logic [IN_W-1:0]        next2_above,
  input  logic [IN_W-1:0]        next2_below,
  input  logic [IN_W-1:0]        spatial_pred,
  output logic                   s1_valid,
  output logic [SAMPLE_BITS-1:0] s1_avg,
  output logic [SAMPLE_BITS-1:0] s1_avg_a,
  output logic [SAMPLE_BITS-1:0] s1_avg_b,
  output logic [SAMPLE_BITS-1:0] s1_up,
  output logic [SAMPLE_BITS-1:0] s1_dn,
  output logic [SAMPLE_BITS-1:0] s1_pred,
  output logic [SAMPLE_BITS-1:0] s1_t0,
  output logic [SAMPLE_BITS-1:0] s1_d1,
  output logic [SAMPLE_BITS-1:0] s1_d2,
  output logic [SAMPLE_BITS-1:0] s1_d3,
  output logic [SAMPLE_BITS-1:0] s1_d4
);

  localparam int unsigned SB = SAMPLE_BITS;

  logic [SB-1:0] pv2a, pv2b, prv_2a, nxt_2a, prv, nxt, prv_2b, nxt_2b;
  logic [SB-1:0] up, dn, nx2a, nx2b, pred;
  logic [SB:0]   sum_c, sum_a, sum_b;

  logic          valid_r;
  logic [SB-1:0] avg_r, avg_a_r, avg_b_r, up_r, dn_r, pred_r;
  logic [SB-1:0] t0_r, d1_r, d2_r, d3_r, d4_r;
  logic [SB-1:0] avg_nxt, avg_a_nxt, avg_b_nxt, t0_nxt, d1_nxt, d2_nxt, d3_nxt, d4_nxt;

  function automatic logic [SB-1:0] absdiff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Keep only the low sample bits of every field and pair half.
  always_comb begin
    pv2a   = prev2_above[SB-1:0];
    pv2b   = prev2_below[SB-1:0];
    prv_2a = pair_two_above[SB-1:0];
    nxt_2a = pair_two_above[IN_W +: SB];
    prv    = prev_at_line[SB-1:0];
    nxt    = next_at_line[SB-1:0];
    prv_2b = pair_two_below[SB-1:0];
    nxt_2b = pair_two_below[IN_W +: SB];
    up     = cur_above[SB-1:0];
    dn     = cur_below[SB-1:0];
    nx2a   = next2_above[SB-1:0];
    nx2b   = next2_below[SB-1:0];
    pred   = spatial_pred[SB-1:0];
  end

  // Form averages and absolute differences.
  always_comb begin
    sum_c     = {1'b0, prv} + {1'b0, nxt};
    sum_a     = {1'b0, prv_2a} + {1'b0, nxt_2a};
    sum_b     = {1'b0, prv_2b} + {1'b0, nxt_2b};
    avg_nxt   = sum_c[SB:1];
    avg_a_nxt = sum_a[SB:1];
    avg_b_nxt = sum_b[SB:1];
    t0_nxt    = absdiff(prv, nxt);
    d1_nxt    = absdiff(pv2a, up);
    d2_nxt    = absdiff(pv2b, dn);
    d3_nxt    = absdiff(nx2a, up);
    d4_nxt    = absdiff(nx2b, dn);
  end

  // Advance the valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Capture the stage payload.
  always_ff @(posedge clk) begin
    avg_r   <= avg_nxt;
    avg_a_r <= avg_a_nxt;
    avg_b_r <= avg_b_nxt;
    up_r    <= up;
    dn_r    <= dn;
    pred_r  <= pred;
    t0_r    <= t0_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    d3_r    <= d3_nxt;
    d4_r    <= d4_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_avg   = avg_r;
  assign s1_avg_a = avg_a_r;
  assign s1_avg_b = avg_b_r;
  assign s1_up    = up_r;
  assign s1_dn    = dn_r;
  assign s1_pred  = pred_r;
  assign s1_t0    = t0_r;
  assign s1_d1    = d1_r;
  assign s1_d2    = d2_r;
  assign s1_d3    = d3_r;
  assign s1_d4    = d4_r;

endmodule

FILE: hdl/ytc_bound.sv
// Stages two and three: temporal bound and its spatial min/max widening.
module ytc_bound
  import ytc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   skip_spatial_check,
  input  logic                   s1_valid,
  input  logic [SAMPLE_BITS-1:0] s1_avg,
  input  logic [SAMPLE_BITS-1:0] s1_avg_a,
  input  logic [SAMPLE_BITS-1:0] s1_avg_b,
  input  logic [SAMPLE_BITS-1:0] s1_up,
  input  logic [SAMPLE_BITS-1:0] s1_dn,
  input  logic [SAMPLE_BITS-1:0] s1_pred,
  input  logic [SAMPLE_BITS-1:0] s1_t0,
  input  logic [SAMPLE_BITS-1:0] s1_d1,
  input  logic [SAMPLE_BITS-1:0] s1_d2,
  input  logic [SAMPLE_BITS-1:0] s1_d3,
  input  logic [SAMPLE_BITS-1:0] s1_d4,
  output logic                   s3_valid,
  output logic [SAMPLE_BITS-1:0] s3_avg,
  output logic [SAMPLE_BITS-1:0] s3_bound,
  output logic [SAMPLE_BITS-1:0] s3_pred
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SW = SAMPLE_BITS + 2;

  logic signed [SW-1:0] a_dn, a_up, aa_up, ab_dn, hi_nxt, lo_nxt;
  logic [SB:0]          sum1, sum2;
  logic [SB-1:0]        t0h, t1, t2, tb_nxt;

  logic                 v2_r;
  logic [SB-1:0]        tb_r, avg2_r, pred2_r;
  logic signed [SW-1:0] hi_r, lo_r;

  logic signed [SW-1:0] tb_s, neg_hi, wide;
  logic [SB-1:0]        bound_nxt;
  logic                 v3_r;
  logic [SB-1:0]        bound_r, avg3_r, pred3_r;

  function automatic logic signed [SW-1:0] sx(input logic [SB-1:0] a);
    return $signed({2'b00, a});
  endfunction

  function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Stage two: temporal bound and spatial min/max terms.
  always_comb begin
    sum1   = {1'b0, s1_d1} + {1'b0, s1_d2};
    sum2   = {1'b0, s1_d3} + {1'b0, s1_d4};
    t0h    = s1_t0 >> 1;
    t1     = sum1[SB:1];
    t2     = sum2[SB:1];
    tb_nxt = t0h;
    if (t1 > tb_nxt) begin
      tb_nxt = t1;
    end
    if (t2 > tb_nxt) begin
      tb_nxt = t2;
    end
    a_dn   = sx(s1_avg) - sx(s1_dn);
    a_up   = sx(s1_avg) - sx(s1_up);
    aa_up  = sx(s1_avg_a) - sx(s1_up);
    ab_dn  = sx(s1_avg_b) - sx(s1_dn);
    hi_nxt = smax(smax(a_dn, a_up), smin(aa_up, ab_dn));
    lo_nxt = smin(smin(a_dn, a_up), smax(aa_up, ab_dn));
  end

  // Advance the valid bits of stages two and three.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= s1_valid;
      v3_r <= v2_r;
    end
  end

  // Capture the stage two payload.
  always_ff @(posedge clk) begin
    tb_r    <= tb_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    avg2_r  <= s1_avg;
    pred2_r <= s1_pred;
  end

  // Stage three: widen the bound unless the spatial check is skipped.
  always_comb begin
    tb_s   = sx(tb_r);
    neg_hi = -hi_r;
    wide   = smax(smax(tb_s, lo_r), neg_hi);
    if (skip_spatial_check) begin
      bound_nxt = tb_r;
    end else begin
      bound_nxt = wide[SB-1:0];
    end
  end

  // Capture the stage three payload.
  always_ff @(posedge clk) begin
    bound_r <= bound_nxt;
    avg3_r  <= avg2_r;
    pred3_r <= pred2_r;
  end

  assign s3_valid = v3_r;
  assign s3_avg   = avg3_r;
  assign s3_bound = bound_r;
  assign s3_pred  = pred3_r;

endmodule

FILE: hdl/ytc_clamp.sv
// Stage four: clamp the spatial prediction into the average plus or minus the bound.
module ytc_clamp
  import ytc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s3_valid,
  input  logic [SAMPLE_BITS-1:0] s3_avg,
  input  logic [SAMPLE_BITS-1:0] s3_bound,
  input  logic [SAMPLE_BITS-1:0] s3_pred,
  output logic                   out_valid,
  output logic [IN_W-1:0]        out_sample
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SW = SAMPLE_BITS + 2;

  logic [SB:0]          upper;
  logic signed [SW-1:0] lower, pred_s;
  logic [SB-1:0]        res_nxt;
  logic                 valid_r;
  logic [SB-1:0]        res_r;

  // Compare the prediction against both limits.
  always_comb begin
    upper  = {1'b0, s3_avg} + {1'b0, s3_bound};
    lower  = $signed({2'b00, s3_avg}) - $signed({2'b00, s3_bound});
    pred_s = $signed({2'b00, s3_pred});
    priority if ({1'b0, s3_pred} > upper) begin
      res_nxt = upper[SB-1:0];
    end else if (pred_s < lower) begin
      res_nxt = lower[SB-1:0];
    end else begin
      res_nxt = s3_pred;
    end
  end

  // Advance the output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s3_valid;
    end
  end

  // Hold the result for its strobe cycle.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_sample = IN_W'(res_r);

endmodule

FILE: tb/ytc_clamp_checker.sv
// Checker for the temporal clamp: watches requests and results, predicts and compares.
`timescale 1ns / 100ps

module ytc_clamp_checker
  import ytc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [IN_W-1:0]   in_prev2_above,
  input  logic [IN_W-1:0]   in_prev2_below,
  input  logic [PAIR_W-1:0] in_pair_two_above,
  input  logic [IN_W-1:0]   in_prev_at_line,
  input  logic [IN_W-1:0]   in_next_at_line,
  input  logic [PAIR_W-1:0] in_pair_two_below,
  input  logic [IN_W-1:0]   in_cur_above,
  input  logic [IN_W-1:0]   in_cur_below,
  input  logic [IN_W-1:0]   in_next2_above,
  input  logic [IN_W-1:0]   in_next2_below,
  input  logic [IN_W-1:0]   in_spatial_pred,
  input  logic              out_valid,
  input  logic [IN_W-1:0]   out_sample,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output int unsigned       pixels_open,
  output int unsigned       mismatch_count
);

  localparam int SMASK = (1 << SAMPLE_BITS) - 1;

  logic [IN_W-1:0] expected_pixels [$];
  logic            skip_spatial = 1'b0;
  int unsigned     fails = 0;

  function automatic int smp(input logic [IN_W-1:0] v);
    return int'(v) & SMASK;
  endfunction

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int min_i(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Clamp the spatial prediction into the temporal average plus or minus the bound.
  function automatic logic [IN_W-1:0] clamp_expect(
    input logic [IN_W-1:0]   p2a, p2b,
    input logic [PAIR_W-1:0] pair_a,
    input logic [IN_W-1:0]   prv_l, nxt_l,
    input logic [PAIR_W-1:0] pair_b,
    input logic [IN_W-1:0]   cur_a, cur_b, n2a, n2b, pred_in,
    input logic              skip
  );
    int prv, nxt, up, dn, pred, avg, t0, t1, t2, bnd, avg_a, avg_b, hi, lo, res;
    prv  = smp(prv_l);
    nxt  = smp(nxt_l);
    up   = smp(cur_a);
    dn   = smp(cur_b);
    pred = smp(pred_in);
    avg  = (prv + nxt) >>> 1;
    t0   = abs_gap(prv, nxt);
    t1   = (abs_gap(smp(p2a), up) + abs_gap(smp(p2b), dn)) >>> 1;
    t2   = (abs_gap(smp(n2a), up) + abs_gap(smp(n2b), dn)) >>> 1;
    bnd  = max_i(max_i(t0 >>> 1, t1), t2);
    // widen the bound by the spatial min/max terms
    if (!skip) begin
      avg_a = (smp(pair_a[IN_W-1:0]) + smp(pair_a[PAIR_W-1:IN_W])) >>> 1;
      avg_b = (smp(pair_b[IN_W-1:0]) + smp(pair_b[PAIR_W-1:IN_W])) >>> 1;
      hi = max_i(max_i(avg - dn, avg - up), min_i(avg_a - up, avg_b - dn));
      lo = min_i(min_i(avg - dn, avg - up), max_i(avg_a - up, avg_b - dn));
      bnd = max_i(max_i(bnd, lo), -hi);
    end
    if (pred > avg + bnd)
      res = avg + bnd;
    else if (pred < avg - bnd)
      res = avg - bnd;
    else
      res = pred;
    return res[IN_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [IN_W-1:0] want;
    if (!rst_n) begin
      expected_pixels.delete();
      skip_spatial = 1'b0;
    end else begin
      // compare each result with the oldest open request
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no open request: expected none, actual %h",
                   $time, out_sample);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_sample !== want) begin
            $display("%0t: out_sample mismatch: expected %h, actual %h",
                     $time, want, out_sample);
            fails++;
          end
        end
      end
      // predict each accepted request with the current setting
      if (start && !busy)
        expected_pixels.push_back(clamp_expect(
          in_prev2_above, in_prev2_below, in_pair_two_above, in_prev_at_line,
          in_next_at_line, in_pair_two_below, in_cur_above, in_cur_below,
          in_next2_above, in_next2_below, in_spatial_pred, skip_spatial));
      // track the register
      if (cfg_we)
        skip_spatial = cfg_wdata;
    end
    pixels_open    <= expected_pixels.size();
    mismatch_count <= fails;
  end

endmodule

FILE: tb/yadif_temporal_clamp_pixel_tb.sv
// Testbench top for the temporal clamp: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module yadif_temporal_clamp_pixel_tb;
  import ytc_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [IN_W-1:0]   in_prev2_above;
  logic [IN_W-1:0]   in_prev2_below;
  logic [PAIR_W-1:0] in_pair_two_above;
  logic [IN_W-1:0]   in_prev_at_line;
  logic [IN_W-1:0]   in_next_at_line;
  logic [PAIR_W-1:0] in_pair_two_below;
  logic [IN_W-1:0]   in_cur_above;
  logic [IN_W-1:0]   in_cur_below;
  logic [IN_W-1:0]   in_next2_above;
  logic [IN_W-1:0]   in_next2_below;
  logic [IN_W-1:0]   in_spatial_pred;
  logic              out_valid;
  logic [IN_W-1:0]   out_sample;
  logic              cfg_we;
  logic              cfg_wdata;
  int unsigned       pixels_open;
  int unsigned       mismatch_count;

  localparam logic [IN_W-1:0]   SMAX = '1;
  localparam logic [PAIR_W-1:0] PMAX = '1;

  yadif_temporal_clamp_pixel u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_prev2_above    (in_prev2_above),
    .in_prev2_below    (in_prev2_below),
    .in_pair_two_above (in_pair_two_above),
    .in_prev_at_line   (in_prev_at_line),
    .in_next_at_line   (in_next_at_line),
    .in_pair_two_below (in_pair_two_below),
    .in_cur_above      (in_cur_above),
    .in_cur_below      (in_cur_below),
    .in_next2_above    (in_next2_above),
    .in_next2_below    (in_next2_below),
    .in_spatial_pred   (in_spatial_pred),
    .out_valid         (out_valid),
    .out_sample        (out_sample),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  ytc_clamp_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_prev2_above    (in_prev2_above),
    .in_prev2_below    (in_prev2_below),
    .in_pair_two_above (in_pair_two_above),
    .in_prev_at_line   (in_prev_at_line),
    .in_next_at_line   (in_next_at_line),
    .in_pair_two_below (in_pair_two_below),
    .in_cur_above      (in_cur_above),
    .in_cur_below      (in_cur_below),
    .in_next2_above    (in_next2_above),
    .in_next2_below    (in_next2_below),
    .in_spatial_pred   (in_spatial_pred),
    .out_valid         (out_valid),
    .out_sample        (out_sample),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .pixels_open       (pixels_open),
    .mismatch_count    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one request and hold it until it is taken.
  task automatic issue(
    input logic [IN_W-1:0]   p2a, p2b,
    input logic [PAIR_W-1:0] pair_a,
    input logic [IN_W-1:0]   prv, nxt,
    input logic [PAIR_W-1:0] pair_b,
    input logic [IN_W-1:0]   up, dn, n2a, n2b, pred
  );
    start             <= 1'b1;
    in_prev2_above    <= p2a;
    in_prev2_below    <= p2b;
    in_pair_two_above <= pair_a;
    in_prev_at_line   <= prv;
    in_next_at_line   <= nxt;
    in_pair_two_below <= pair_b;
    in_cur_above      <= up;
    in_cur_below      <= dn;
    in_next2_above    <= n2a;
    in_next2_below    <= n2b;
    in_spatial_pred   <= pred;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every open request has its result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pixels_open != 0);
  endtask

  task automatic set_skip(input logic skip);
    drain();
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= skip;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[IN_W-1:0];
  endfunction

  // Hand-picked corners: extremes, each clamp direction, each bound term.
  task automatic directed_pixels();
    issue(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(SMAX, SMAX, PMAX, SMAX, SMAX, PMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    issue(1000, 1000, {16'd1000, 16'd1000}, 1000, 1000, {16'd1000, 16'd1000},
          1000, 1000, 1000, 1000, SMAX);
    issue(1000, 1000, {16'd1000, 16'd1000}, 1000, 1000, {16'd1000, 16'd1000},
          1000, 1000, 1000, 1000, 0);
    issue(500, 700, {16'd600, 16'd640}, 600, 640, {16'd610, 16'd650},
          620, 630, 590, 660, 620);
    issue(0, 0, 0, 0, SMAX, 0, 0, 0, 0, 0, SMAX);
    issue(0, 65000, {16'd40000, 16'd40000}, 40000, 40000, {16'd40000, 16'd40000},
          40000, 1000, 40000, 1000, 0);
    issue(40000, 1000, {16'd40000, 16'd40000}, 40000, 40000, {16'd40000, 16'd40000},
          40000, 1000, 0, 65000, SMAX);
    issue(1000, 1000, {16'd60000, 16'd60000}, 50000, 50000, {16'd60000, 16'd60000},
          1000, 1000, 1000, 1000, 0);
    issue(50000, 50000, 0, 1000, 1000, 0, 50000, 50000, 50000, 50000, SMAX);
    issue(20000, 30000, {16'h0000, 16'hFFFF}, 20000, 22000, {16'hFFFF, 16'h0001},
          21000, 25000, 19000, 31000, 40000);
    issue(3000, 3100, {16'd3050, 16'd3020}, 3000, 3010, {16'd3200, 16'd2900},
          3005, 3050, 3010, 3080, 3300);
  endtask

  // One random request: mostly smooth pictures with some motion, some noise.
  task automatic random_pixel(input int idle_pct);
    logic [IN_W-1:0] s [13];
    int kind, base, spread;
    kind   = $urandom_range(9);
    base   = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : 65535)
                                      : $urandom_range(65535);
    spread = $urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
    for (int i = 0; i < 13; i++) begin
      if (kind < 3)
        s[i] = IN_W'($urandom);
      else if (kind == 9)
        s[i] = $urandom_range(1) ? SMAX : '0;
      else
        s[i] = near(base, spread);
    end
    // pull prev and next at the line apart for motion
    if (kind == 8) begin
      s[4] = near($urandom_range(1) ? 0 : 65535, spread);
      s[5] = near($urandom_range(65535), spread);
    end
    // move the spatial prediction anywhere in half of the smooth and motion requests
    if (kind >= 3 && kind < 9 && $urandom_range(1))
      s[12] = IN_W'($urandom);
    // idle the sender in about idle_pct cycles of a hundred
    while ($urandom_range(99) < idle_pct)
      pause(1);
    issue(s[0], s[1], {s[3], s[2]}, s[4], s[5], {s[7], s[6]},
          s[8], s[9], s[10], s[11], s[12]);
  endtask

  task automatic random_phase(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        drain();
      random_pixel(idle_pct);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    in_prev2_above    <= '0;
    in_prev2_below    <= '0;
    in_pair_two_above <= '0;
    in_prev_at_line   <= '0;
    in_next_at_line   <= '0;
    in_pair_two_below <= '0;
    in_cur_above      <= '0;
    in_cur_below      <= '0;
    in_next2_above    <= '0;
    in_next2_below    <= '0;
    in_spatial_pred   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // corners with the spatial check on, then off
    set_skip(1'b0);
    directed_pixels();
    set_skip(1'b1);
    directed_pixels();

    // random traffic under each setting and sender pace
    set_skip(1'b0);
    random_phase(135, 35);
    set_skip(1'b1);
    random_phase(135, 65);
    set_skip(1'b0);
    random_phase(130, 0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pixels_open == 0)
      $display("** yadif_temporal_clamp_pixel: PASSED **");
    else
      $display("** yadif_temporal_clamp_pixel: FAILED **");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #100000;
    $display("** yadif_temporal_clamp_pixel: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ytc_pkg.sv
hdl/ytc_diff.sv
hdl/ytc_bound.sv
hdl/ytc_clamp.sv
hdl/yadif_temporal_clamp_pixel.sv
tb/ytc_clamp_checker.sv
tb/yadif_temporal_clamp_pixel_tb.sv
